// ===== rtl/core/assert_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the level alarm checker.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/laa_pkg.sv =====
// ------------------------------------------------------------------------
// Level alarm package
// Codes, register indexes, reset values and types shared by the block.
// ------------------------------------------------------------------------
package laa_pkg;

    localparam int unsigned DataW = 16;
    localparam int unsigned IdxW  = 3;

    // input modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_ACK    = 2'd2;

    // alert levels
    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_LOW  = 2'd1;
    localparam logic [1:0] LVL_MID  = 2'd2;
    localparam logic [1:0] LVL_HIGH = 2'd3;

    // configuration register indexes
    localparam logic [IdxW-1:0] REG_THR_LOW     = 3'd0;
    localparam logic [IdxW-1:0] REG_THR_MID     = 3'd1;
    localparam logic [IdxW-1:0] REG_THR_HIGH    = 3'd2;
    localparam logic [IdxW-1:0] REG_ON_LOW_MID  = 3'd3;
    localparam logic [IdxW-1:0] REG_ON_HIGH     = 3'd4;
    localparam logic [IdxW-1:0] REG_OFF_LOW     = 3'd5;
    localparam logic [IdxW-1:0] REG_OFF_MID     = 3'd6;
    localparam logic [IdxW-1:0] REG_OFF_HIGH    = 3'd7;

    // register reset values
    localparam logic signed [DataW-1:0] RST_THR_LOW    = 16'sd8000;
    localparam logic signed [DataW-1:0] RST_THR_MID    = 16'sd8200;
    localparam logic signed [DataW-1:0] RST_THR_HIGH   = 16'sd8400;
    localparam logic [DataW-1:0]        RST_ON_LOW_MID = 16'd80;
    localparam logic [DataW-1:0]        RST_ON_HIGH    = 16'd70;
    localparam logic [DataW-1:0]        RST_OFF_LOW    = 16'd1200;
    localparam logic [DataW-1:0]        RST_OFF_MID    = 16'd800;
    localparam logic [DataW-1:0]        RST_OFF_HIGH   = 16'd70;

    localparam logic [DataW-1:0] TICKS_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [DataW-1:0] thr_low;
        logic signed [DataW-1:0] thr_mid;
        logic signed [DataW-1:0] thr_high;
        logic [DataW-1:0]        on_low_mid;
        logic [DataW-1:0]        on_high;
        logic [DataW-1:0]        off_low;
        logic [DataW-1:0]        off_mid;
        logic [DataW-1:0]        off_high;
    } t_cfg;

endpackage

// ===== rtl/core/laa_ifs.sv =====
// ------------------------------------------------------------------------
// Level alarm channels
// Valid/ready channels for samples, results and configuration writes.
// ------------------------------------------------------------------------
interface laa_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] volume;

    modport source(output valid, mode, volume, input ready);
    modport sink(input valid, mode, volume, output ready);
endinterface

interface laa_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] alert_level;
    logic       buzzer_on;
    logic       acknowledged;

    modport source(output valid, alert_level, buzzer_on, acknowledged, input ready);
    modport sink(input valid, alert_level, buzzer_on, acknowledged, output ready);
endinterface

interface laa_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/laa_cfg_regs.sv =====
// ------------------------------------------------------------------------
// Level alarm configuration registers
// Holds thresholds and buzzer periods, written one register per transaction.
// ------------------------------------------------------------------------
module laa_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    laa_cfg_if.sink       i_cfg_ch,
    output laa_pkg::t_cfg o_cfg
);
    import laa_pkg::*;

    t_cfg r_cfg;

    // always able to take a write
    assign i_cfg_ch.ready = 1'b1;
    assign o_cfg          = r_cfg;

    // load defaults at reset, then update the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_low    <= RST_THR_LOW;
            r_cfg.thr_mid    <= RST_THR_MID;
            r_cfg.thr_high   <= RST_THR_HIGH;
            r_cfg.on_low_mid <= RST_ON_LOW_MID;
            r_cfg.on_high    <= RST_ON_HIGH;
            r_cfg.off_low    <= RST_OFF_LOW;
            r_cfg.off_mid    <= RST_OFF_MID;
            r_cfg.off_high   <= RST_OFF_HIGH;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                REG_THR_LOW:    r_cfg.thr_low    <= i_cfg_ch.data;
                REG_THR_MID:    r_cfg.thr_mid    <= i_cfg_ch.data;
                REG_THR_HIGH:   r_cfg.thr_high   <= i_cfg_ch.data;
                REG_ON_LOW_MID: r_cfg.on_low_mid <= i_cfg_ch.data;
                REG_ON_HIGH:    r_cfg.on_high    <= i_cfg_ch.data;
                REG_OFF_LOW:    r_cfg.off_low    <= i_cfg_ch.data;
                REG_OFF_MID:    r_cfg.off_mid    <= i_cfg_ch.data;
                REG_OFF_HIGH:   r_cfg.off_high   <= i_cfg_ch.data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/level_alarm_annunciator.sv =====
// ------------------------------------------------------------------------
// Level alarm annunciator
// Classifies tank volume samples into alert levels and drives a buzzer.
// ------------------------------------------------------------------------
// Usage:
//   i_in_ch carries one transaction per event: a millisecond tick, a
//   volume sample or an acknowledge press (mode field). Every input
//   transaction yields exactly one result on o_res_ch with the alert
//   level, buzzer state and acknowledge flag after that event.
//   i_cfg_ch writes thresholds and buzzer periods; write it only while
//   no transaction is in flight. It is always ready.
//   Path: an accepted transaction passes the input register, then the
//   result register, which feeds o_res_ch. Throughput: one
//   transaction per cycle while the receiver does not stall; the alarm
//   state update is a single compare/increment step between the two
//   registers.
//   Reset: level none, acknowledge clear, buzzer off phase, tick counter
//   zero, configuration at its default values; both stages empty.
//   Receiver stall: the result register holds; the input register keeps
//   accepting until it is full, then i_in_ch.ready drops.
// ------------------------------------------------------------------------
module level_alarm_annunciator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    laa_in_if.sink    i_in_ch,
    laa_cfg_if.sink   i_cfg_ch,
    laa_out_if.source o_res_ch
);
    import laa_pkg::*;

    t_cfg cfg;

    // input stage
    logic                    r_in_valid;
    logic [1:0]              r_in_mode;
    logic signed [DataW-1:0] r_in_volume;

    // alarm state
    logic [1:0]       r_level, n_level;
    logic             r_ack, n_ack;
    logic             r_phase, n_phase;
    logic [DataW-1:0] r_elapsed, n_elapsed;

    // result stage
    logic       r_out_valid;
    logic [1:0] r_out_level;
    logic       r_out_buzz;
    logic       r_out_ack;

    logic             res_free;
    logic             step;
    logic             alarm_active;
    logic [DataW-1:0] elapsed_inc;
    logic [DataW-1:0] on_t;
    logic [DataW-1:0] off_t;
    logic             n_buzz;

    laa_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg_ch(i_cfg_ch),
        .o_cfg   (cfg)
    );

    // handshake between the two stages
    assign res_free       = !r_out_valid || o_res_ch.ready;
    assign step           = r_in_valid && res_free;
    assign i_in_ch.ready  = !r_in_valid || res_free;

    // hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_in_mode   <= i_in_ch.mode;
            r_in_volume <= i_in_ch.volume;
        end
    end

    // pick the buzzer periods for the current level
    always_comb begin
        case (r_level)
            LVL_HIGH: begin
                on_t  = cfg.on_high;
                off_t = cfg.off_high;
            end
            LVL_MID: begin
                on_t  = cfg.on_low_mid;
                off_t = cfg.off_mid;
            end
            default: begin
                on_t  = cfg.on_low_mid;
                off_t = cfg.off_low;
            end
        endcase
    end

    assign alarm_active = (r_level != LVL_NONE) && (!r_ack || r_level == LVL_HIGH);
    assign elapsed_inc  = (r_elapsed == TICKS_MAX) ? r_elapsed : r_elapsed + 16'd1;

    // next alarm state for the held transaction
    always_comb begin
        n_level   = r_level;
        n_ack     = r_ack;
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        case (r_in_mode)
            MODE_TICK: begin
                n_elapsed = elapsed_inc;
                if (alarm_active) begin
                    if (r_phase) begin
                        if (elapsed_inc > on_t) begin
                            n_phase   = 1'b0;
                            n_elapsed = '0;
                        end
                    end else if (elapsed_inc > off_t) begin
                        n_phase   = 1'b1;
                        n_elapsed = '0;
                    end
                end
            end
            MODE_SAMPLE: begin
                if (r_in_volume > cfg.thr_high) begin
                    n_level = LVL_HIGH;
                    n_ack   = 1'b0;
                end else if (r_in_volume > cfg.thr_mid) begin
                    if (r_level != LVL_MID) begin
                        n_level = LVL_MID;
                        n_ack   = 1'b0;
                    end
                end else if (r_in_volume > cfg.thr_low) begin
                    if (r_level == LVL_NONE) begin
                        n_ack = 1'b0;
                    end
                    n_level = LVL_LOW;
                end else if (r_level != LVL_NONE) begin
                    n_level = LVL_NONE;
                    n_ack   = 1'b0;
                end
            end
            MODE_ACK: begin
                if (r_level == LVL_LOW || r_level == LVL_MID) begin
                    n_ack = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign n_buzz = n_phase && (n_level != LVL_NONE) && (!n_ack || n_level == LVL_HIGH);

    // advance the alarm state once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= LVL_NONE;
            r_ack     <= 1'b0;
            r_phase   <= 1'b0;
            r_elapsed <= '0;
        end else if (step) begin
            r_level   <= n_level;
            r_ack     <= n_ack;
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_level <= n_level;
            r_out_buzz  <= n_buzz;
            r_out_ack   <= n_ack;
        end
    end

    assign o_res_ch.valid        = r_out_valid;
    assign o_res_ch.alert_level  = r_out_level;
    assign o_res_ch.buzzer_on    = r_out_buzz;
    assign o_res_ch.acknowledged = r_out_ack;

endmodule

// ===== rtl/core/laa_checker.sv =====
// ------------------------------------------------------------------------
// Level alarm checker
// Port-level checks on the result channel of the level alarm.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module laa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [1:0] i_res_level,
    input logic       i_res_buzz,
    input logic       i_res_ack
);
    import laa_pkg::*;

    // buzzer never sounds without an alert
    `ASSERT_IMPLY(a_buzz_needs_level, i_clk, i_rst_n, i_res_valid && i_res_buzz, i_res_level != LVL_NONE)

    // only low and medium alerts can be acknowledged
    `ASSERT_IMPLY(a_ack_level, i_clk, i_rst_n, i_res_valid && i_res_ack, i_res_level == LVL_LOW || i_res_level == LVL_MID)

    // an acknowledged alert is silent
    `ASSERT_IMPLY(a_ack_silent, i_clk, i_rst_n, i_res_valid && i_res_ack, !i_res_buzz)

    // a stalled result holds
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_level) && $stable(i_res_buzz) && $stable(i_res_ack))

endmodule

bind level_alarm_annunciator laa_checker u_laa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_res_valid(o_res_ch.valid),
    .i_res_ready(o_res_ch.ready),
    .i_res_level(o_res_ch.alert_level),
    .i_res_buzz (o_res_ch.buzzer_on),
    .i_res_ack  (o_res_ch.acknowledged)
);

// ===== tb/sv/laa_alarm_checker.sv =====
// ------------------------------------------------------------------------
// Level alarm checker
// Watches the sample, configuration and result channels of the level
// alarm, keeps its own copy of the alarm state and of the thresholds and
// periods, and compares every result with the status it predicts.
// ------------------------------------------------------------------------
module laa_alarm_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    laa_in_if    i_in_mon,
    laa_cfg_if   i_cfg_mon,
    laa_out_if   i_res_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_beeps
);
    import laa_pkg::*;

    typedef struct packed {
        logic [1:0] alert_level;
        logic       buzzer_on;
        logic       acknowledged;
    } t_status;

    // alarm state as the block should hold it
    t_cfg        alarm_cfg;
    logic [1:0]  level;
    logic        ack;
    logic        phase;
    logic [15:0] ticks;

    t_status     status_q[$];
    int          fails;
    int          checked;
    int          beeps;
    int          outstanding;

    assign o_fail_count = fails;
    assign o_pending    = outstanding;
    assign o_checked    = checked;
    assign o_beeps      = beeps;

    // Advance the alarm by one event and return the status it shows after it
    function automatic t_status advance_alarm(input logic [1:0] m,
                                              input logic signed [15:0] v);
        t_status     s;
        logic [15:0] on_t;
        logic [15:0] off_t;
        case (m)
            MODE_TICK: begin
                if (ticks != TICKS_MAX) ticks = ticks + 16'd1;
                // silenced or idle alarms only count
                if (level != LVL_NONE && (!ack || level == LVL_HIGH)) begin
                    on_t = (level == LVL_HIGH) ? alarm_cfg.on_high : alarm_cfg.on_low_mid;
                    if (level == LVL_HIGH)
                        off_t = alarm_cfg.off_high;
                    else if (level == LVL_MID)
                        off_t = alarm_cfg.off_mid;
                    else
                        off_t = alarm_cfg.off_low;
                    if (phase) begin
                        if (ticks > on_t) begin
                            phase = 1'b0;
                            ticks = '0;
                        end
                    end else if (ticks > off_t) begin
                        phase = 1'b1;
                        ticks = '0;
                    end
                end
            end
            MODE_SAMPLE: begin
                // thresholds are tried top down, whatever their order
                if (v > $signed(alarm_cfg.thr_high)) begin
                    level = LVL_HIGH;
                    ack   = 1'b0;
                end else if (v > $signed(alarm_cfg.thr_mid)) begin
                    if (level != LVL_MID) begin
                        level = LVL_MID;
                        ack   = 1'b0;
                    end
                end else if (v > $signed(alarm_cfg.thr_low)) begin
                    if (level == LVL_NONE) ack = 1'b0;
                    level = LVL_LOW;
                end else if (level != LVL_NONE) begin
                    level = LVL_NONE;
                    ack   = 1'b0;
                end
            end
            MODE_ACK: begin
                if (level == LVL_LOW || level == LVL_MID) ack = 1'b1;
            end
            default: ;
        endcase
        s.alert_level  = level;
        s.buzzer_on    = phase && level != LVL_NONE && (!ack || level == LVL_HIGH);
        s.acknowledged = ack;
        return s;
    endfunction

    // Track writes, predict on input transactions, compare on results
    always @(posedge i_clk) begin : monitor
        t_status want;
        if (!i_rst_n) begin
            alarm_cfg.thr_low    = RST_THR_LOW;
            alarm_cfg.thr_mid    = RST_THR_MID;
            alarm_cfg.thr_high   = RST_THR_HIGH;
            alarm_cfg.on_low_mid = RST_ON_LOW_MID;
            alarm_cfg.on_high    = RST_ON_HIGH;
            alarm_cfg.off_low    = RST_OFF_LOW;
            alarm_cfg.off_mid    = RST_OFF_MID;
            alarm_cfg.off_high   = RST_OFF_HIGH;
            level       = LVL_NONE;
            ack         = 1'b0;
            phase       = 1'b0;
            ticks       = '0;
            fails       = 0;
            checked     = 0;
            beeps       = 0;
            outstanding = 0;
            status_q.delete();
        end else begin
            if (i_cfg_mon.valid === 1'b1 && i_cfg_mon.ready === 1'b1) begin
                case (i_cfg_mon.index)
                    REG_THR_LOW:    alarm_cfg.thr_low    = i_cfg_mon.data;
                    REG_THR_MID:    alarm_cfg.thr_mid    = i_cfg_mon.data;
                    REG_THR_HIGH:   alarm_cfg.thr_high   = i_cfg_mon.data;
                    REG_ON_LOW_MID: alarm_cfg.on_low_mid = i_cfg_mon.data;
                    REG_ON_HIGH:    alarm_cfg.on_high    = i_cfg_mon.data;
                    REG_OFF_LOW:    alarm_cfg.off_low    = i_cfg_mon.data;
                    REG_OFF_MID:    alarm_cfg.off_mid    = i_cfg_mon.data;
                    REG_OFF_HIGH:   alarm_cfg.off_high   = i_cfg_mon.data;
                    default: ;
                endcase
            end
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1)
                status_q.push_back(advance_alarm(i_in_mon.mode, i_in_mon.volume));
            if (i_res_mon.valid === 1'b1 && i_res_mon.ready === 1'b1) begin
                if (status_q.size() == 0) begin
                    fails++;
                    $error("unexpected result: alert_level %0d buzzer_on %0d acknowledged %0d",
                           i_res_mon.alert_level, i_res_mon.buzzer_on,
                           i_res_mon.acknowledged);
                end else begin
                    want = status_q.pop_front();
                    if (i_res_mon.alert_level !== want.alert_level) begin
                        fails++;
                        $error("alert_level: expected %0d, actual %0d",
                               want.alert_level, i_res_mon.alert_level);
                    end
                    if (i_res_mon.buzzer_on !== want.buzzer_on) begin
                        fails++;
                        $error("buzzer_on: expected %0d, actual %0d",
                               want.buzzer_on, i_res_mon.buzzer_on);
                    end
                    if (i_res_mon.acknowledged !== want.acknowledged) begin
                        fails++;
                        $error("acknowledged: expected %0d, actual %0d",
                               want.acknowledged, i_res_mon.acknowledged);
                    end
                    checked++;
                    if (want.buzzer_on) beeps++;
                end
            end
            outstanding = status_q.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// ------------------------------------------------------------------------
// Level alarm testbench
// Drives ticks, volume samples and acknowledge presses into the level
// alarm under several threshold and period settings, with bursty input
// and a stalling result side, and reports the checker's verdict.
// ------------------------------------------------------------------------
module tb;
    import laa_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         HoldCycles  = 60;
    localparam int         SettleCycles = 4;
    localparam int         LimitCycles = 2_000_000;

    logic i_clk;
    logic i_rst_n;

    laa_in_if  in_ch();
    laa_cfg_if cfg_ch();
    laa_out_if res_ch();

    int   fail_count;
    int   pending;
    int   checked;
    int   beeps;
    int   sent;
    int   holds;
    int   settings;
    int   burst_left;
    bit   hold_req;
    bit   steady;
    bit   offering;
    t_cfg cur_cfg;

    level_alarm_annunciator u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .i_cfg_ch (cfg_ch),
        .o_res_ch (res_ch)
    );

    laa_alarm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_cfg_mon    (cfg_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_beeps      (beeps)
    );

    initial i_clk = 1'b0;

    // Clock: 10 units
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one event and hold it until the transaction; idle between bursts
    task automatic send_item(input logic [1:0] m, input logic signed [15:0] v);
        int gap;
        in_ch.valid  <= 1'b1;
        in_ch.mode   <= m;
        in_ch.volume <= v;
        offering = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sent++;
        if (!steady) begin
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 32);
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(0, 3);
                if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    offering = 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        if (offering) begin
            in_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge i_clk); while (pending != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
    endtask

    // Load a full register set while the block is idle
    task automatic apply_config(input t_cfg c);
        drain();
        write_reg(REG_THR_LOW,    c.thr_low);
        write_reg(REG_THR_MID,    c.thr_mid);
        write_reg(REG_THR_HIGH,   c.thr_high);
        write_reg(REG_ON_LOW_MID, c.on_low_mid);
        write_reg(REG_ON_HIGH,    c.on_high);
        write_reg(REG_OFF_LOW,    c.off_low);
        write_reg(REG_OFF_MID,    c.off_mid);
        write_reg(REG_OFF_HIGH,   c.off_high);
        cfg_ch.valid <= 1'b0;
        cur_cfg = c;
        settings++;
    endtask

    // Volumes cluster around the thresholds, with some anywhere in range
    function automatic logic signed [15:0] pick_volume();
        int base;
        case ($urandom_range(0, 9))
            0, 1, 2: base = $urandom;
            3, 4:    base = int'(cur_cfg.thr_low);
            5, 6:    base = int'(cur_cfg.thr_mid);
            default: base = int'(cur_cfg.thr_high);
        endcase
        base = base + $urandom_range(0, 8) - 4;
        return base[15:0];
    endfunction

    task automatic random_items(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_item(MODE_TICK, 16'($urandom));
            else if (r < 80)
                send_item(MODE_SAMPLE, pick_volume());
            else if (r < 96)
                send_item(MODE_ACK, 16'($urandom));
            else
                send_item(MODE_SPARE, 16'($urandom));
        end
    endtask

    // Random settings: mostly ordered thresholds and short periods
    function automatic t_cfg random_cfg();
        t_cfg               c;
        logic signed [15:0] t [3];
        logic signed [15:0] sw;
        for (int k = 0; k < 3; k++) t[k] = 16'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            if (t[0] > t[1]) begin sw = t[0]; t[0] = t[1]; t[1] = sw; end
            if (t[1] > t[2]) begin sw = t[1]; t[1] = t[2]; t[2] = sw; end
            if (t[0] > t[1]) begin sw = t[0]; t[0] = t[1]; t[1] = sw; end
        end
        c.thr_low  = t[0];
        c.thr_mid  = t[1];
        c.thr_high = t[2];
        c.on_low_mid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        c.on_high    = 16'($urandom_range(0, 12));
        c.off_low    = 16'($urandom_range(0, 12));
        c.off_mid    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        c.off_high   = 16'($urandom_range(0, 12));
        return c;
    endfunction

    // Result side: stall on changing patterns, or hold off on request
    initial begin : receiver
        int pat;
        int left;
        bit toggle;
        res_ch.ready <= 1'b0;
        pat = 0;
        left = 0;
        toggle = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HoldCycles - 1) @(posedge i_clk);
                hold_req = 1'b0;
                holds++;
            end else begin
                if (left == 0) begin
                    pat  = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                toggle = ~toggle;
                case (pat)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: res_ch.ready <= toggle;
                endcase
            end
        end
    end

    initial begin : watchdog
        #(LimitCycles * 10);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        t_cfg c;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.mode   <= MODE_TICK;
        in_ch.volume <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_THR_LOW;
        cfg_ch.data  <= '0;
        sent = 0;
        holds = 0;
        settings = 1;
        burst_left = 0;
        hold_req = 1'b0;
        steady = 1'b0;
        offering = 1'b0;
        cur_cfg = '{RST_THR_LOW, RST_THR_MID, RST_THR_HIGH, RST_ON_LOW_MID,
                    RST_ON_HIGH, RST_OFF_LOW, RST_OFF_MID, RST_OFF_HIGH};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the levels at reset settings: escalate, silence, fall back
        send_item(MODE_TICK,   16'sd0);
        send_item(MODE_SPARE,  16'sd0);
        send_item(MODE_ACK,    16'sd0);
        send_item(MODE_SAMPLE, 16'sd8000);
        send_item(MODE_SAMPLE, 16'sd8001);
        send_item(MODE_ACK,    16'sd0);
        send_item(MODE_SAMPLE, 16'sd8201);
        send_item(MODE_ACK,    16'sd0);
        send_item(MODE_SAMPLE, 16'sd8400);
        send_item(MODE_SAMPLE, 16'sd8401);
        send_item(MODE_ACK,    16'sd0);
        send_item(MODE_SAMPLE, 16'sd32767);
        send_item(MODE_SAMPLE, 16'sd8300);
        send_item(MODE_SAMPLE, 16'sd8100);
        send_item(MODE_ACK,    16'sd0);
        send_item(MODE_SAMPLE, -16'sd32768);
        random_items(200);

        // Short periods so the buzzer toggles; level change keeps the phase
        c = '{16'sd100, 16'sd200, 16'sd300, 16'd3, 16'd2, 16'd5, 16'd4, 16'd6};
        apply_config(c);
        send_item(MODE_SAMPLE, 16'sd150);
        repeat (7) send_item(MODE_TICK, 16'sd0);
        send_item(MODE_SAMPLE, 16'sd350);
        random_items(100);
        hold_req = 1'b1;
        random_items(500);

        // Extreme thresholds, zero periods: an active alarm toggles on every tick
        c = '{-16'sd32768, 16'sd0, 16'sd32767, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        apply_config(c);
        random_items(300);

        // Misordered thresholds, some periods at maximum
        c = '{16'sd5000, -16'sd5000, 16'sd10000, 16'hFFFF, 16'd1, 16'hFFFF, 16'd7, 16'd2};
        apply_config(c);
        random_items(400);

        // Every period at maximum: the phase holds while ticks run back to back
        c = '{16'sd1000, 16'sd2000, 16'sd3000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'hFFFF};
        apply_config(c);
        send_item(MODE_SAMPLE, 16'sd1500);
        steady = 1'b1;
        repeat (100) send_item(MODE_TICK, 16'sd0);
        steady = 1'b0;
        random_items(100);

        // Random settings
        repeat (3) begin
            apply_config(random_cfg());
            hold_req = ($urandom_range(0, 1) == 1);
            random_items(140);
        end

        drain();
        repeat (SettleCycles * 2) @(posedge i_clk);
        $display("summary: %0d events over %0d register settings, %0d results checked",
                 sent, settings, checked);
        $display("summary: %0d results with the buzzer sounding, %0d long receiver hold-offs",
                 beeps, holds);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/laa_pkg.sv
rtl/core/laa_ifs.sv
rtl/core/laa_cfg_regs.sv
rtl/core/level_alarm_annunciator.sv
rtl/core/laa_checker.sv
tb/sv/laa_alarm_checker.sv
tb/sv/tb.sv
